[design/qrp_pkg.sv]
// Package with payload types, widths and register codes for the quaternion projection block.
`default_nettype none
package qrp_pkg;

  // Fixed-point formats.
  localparam int QUAT_FRAC_BITS = 14;
  localparam int PT_FRAC        = 12;

  // Datapath widths; some are fixed, the rest derive from these and the quaternion format.
  localparam int T_W    = 34;
  localparam int PROD_W = 50;
  localparam int SUM_W  = ((PROD_W > 16 + 2 * QUAT_FRAC_BITS) ?
                           PROD_W : 16 + 2 * QUAT_FRAC_BITS) + 2;
  localparam int ROT_W  = SUM_W - 2 * QUAT_FRAC_BITS;
  localparam int DEN_W  = ROT_W + 12;
  localparam int NX_W   = ROT_W + 11;
  localparam int NUM_W  = NX_W + 13;
  localparam int MAG_W  = NUM_W;
  localparam int QUO_W  = 11;
  localparam int CMP_W  = (MAG_W > DEN_W - 1 + QUO_W) ? MAG_W : DEN_W - 1 + QUO_W;
  localparam int SX_W   = 14;

  // Configuration register indexes.
  localparam logic [2:0] CFG_PROJ_DIST    = 3'd0;
  localparam logic [2:0] CFG_CUBE_SIZE    = 3'd1;
  localparam logic [2:0] CFG_CENTER_X     = 3'd2;
  localparam logic [2:0] CFG_CENTER_Y     = 3'd3;
  localparam logic [2:0] CFG_SCREEN_WIDTH = 3'd4;
  localparam logic [2:0] CFG_CONTENT_TOP  = 3'd5;
  localparam logic [2:0] CFG_Y_LIMIT      = 3'd6;

  typedef struct packed {
    logic signed [15:0] quat_r;
    logic signed [15:0] quat_i;
    logic signed [15:0] quat_j;
    logic signed [15:0] quat_k;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
  } qrp_in_t;

  typedef struct packed {
    logic [9:0]         screen_x;
    logic [9:0]         screen_y;
    logic signed [15:0] rotated_depth;
    logic               behind_viewer;
  } qrp_out_t;

  // One coordinate inside the long divider.
  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic             sat;
    logic             neg;
  } div_lane_t;

  // Everything that travels through one divider step.
  typedef struct packed {
    logic               valid;
    logic               behind;
    logic signed [15:0] depth;
    logic [DEN_W-2:0]   den;
    div_lane_t          x;
    div_lane_t          y;
  } div_word_t;

endpackage
`default_nettype wire

[design/quaternion_rotate_and_project.sv]
// Each point passes six arithmetic stages, one divider setup stage, eleven divider
// steps (one quotient bit each) and the output register; one point per cycle is
// taken while the output buffer is not full.
// A two-entry output buffer takes results while the consumer stalls; the input
// stalls only once that buffer is full. Reset clears all valid bits and loads the
// register defaults; no clearing pass is needed.
`default_nettype none
module quaternion_rotate_and_project
  import qrp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire qrp_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output qrp_out_t         out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [11:0] cfg_data_i
);

  localparam int Q2 = 2 * QUAT_FRAC_BITS;
  localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) <<< (Q2 - 1);

  // Configuration registers.
  logic [11:0] proj_dist_q;
  logic [9:0]  cube_size_q, center_x_q, center_y_q;
  logic [9:0]  screen_width_q, content_top_q, y_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proj_dist_q    <= 12'd256;
      cube_size_q    <= 10'd50;
      center_x_q     <= 10'd120;
      center_y_q     <= 10'd140;
      screen_width_q <= 10'd240;
      content_top_q  <= 10'd40;
      y_limit_q      <= 10'd248;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PROJ_DIST:    proj_dist_q    <= cfg_data_i;
        CFG_CUBE_SIZE:    cube_size_q    <= cfg_data_i[9:0];
        CFG_CENTER_X:     center_x_q     <= cfg_data_i[9:0];
        CFG_CENTER_Y:     center_y_q     <= cfg_data_i[9:0];
        CFG_SCREEN_WIDTH: screen_width_q <= cfg_data_i[9:0];
        CFG_CONTENT_TOP:  content_top_q  <= cfg_data_i[9:0];
        CFG_Y_LIMIT:      y_limit_q      <= cfg_data_i[9:0];
        default:          ;
      endcase
    end
  end

  logic signed [10:0] size_s;
  logic signed [12:0] dist_s;
  assign size_s = $signed({1'b0, cube_size_q});
  assign dist_s = $signed({1'b0, proj_dist_q});

  // Pipeline advances unless the output buffer is full.
  logic skid_valid_q, en;
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // Stage 1: t = 2 (v x p).
  logic signed [31:0] jz, ky, kx, iz, iy, jx;
  logic signed [T_W-1:0] tx_d, ty_d, tz_d, tx_q, ty_q, tz_q;
  qrp_in_t s1_q;
  logic v1_q;

  assign jz = in_data_i.quat_j * in_data_i.point_z;
  assign ky = in_data_i.quat_k * in_data_i.point_y;
  assign kx = in_data_i.quat_k * in_data_i.point_x;
  assign iz = in_data_i.quat_i * in_data_i.point_z;
  assign iy = in_data_i.quat_i * in_data_i.point_y;
  assign jx = in_data_i.quat_j * in_data_i.point_x;
  assign tx_d = (T_W'(jz) - T_W'(ky)) <<< 1;
  assign ty_d = (T_W'(kx) - T_W'(iz)) <<< 1;
  assign tz_d = (T_W'(iy) - T_W'(jx)) <<< 1;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= in_data_i;
      tx_q <= tx_d;
      ty_q <= ty_d;
      tz_q <= tz_d;
    end
  end

  // Stage 2: products of the quaternion parts with t.
  logic signed [PROD_W-1:0] rtx_q, rty_q, rtz_q, jtz_q, kty_q, ktx_q, itz_q, ity_q, jtx_q;
  logic signed [15:0] px2_q, py2_q, pz2_q;
  logic v2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rtx_q <= s1_q.quat_r * tx_q;
      rty_q <= s1_q.quat_r * ty_q;
      rtz_q <= s1_q.quat_r * tz_q;
      jtz_q <= s1_q.quat_j * tz_q;
      kty_q <= s1_q.quat_k * ty_q;
      ktx_q <= s1_q.quat_k * tx_q;
      itz_q <= s1_q.quat_i * tz_q;
      ity_q <= s1_q.quat_i * ty_q;
      jtx_q <= s1_q.quat_j * tx_q;
      px2_q <= s1_q.point_x;
      py2_q <= s1_q.point_y;
      pz2_q <= s1_q.point_z;
    end
  end

  // Stage 3: exact sums, rounded to Q12 with ties toward plus infinity.
  logic signed [SUM_W-1:0] sumx, sumy, sumz;
  logic signed [ROT_W-1:0] ox_q, oy_q, oz_q;
  logic v3_q;

  assign sumx = (SUM_W'(px2_q) <<< Q2) + SUM_W'(rtx_q) + SUM_W'(jtz_q) - SUM_W'(kty_q) + RND;
  assign sumy = (SUM_W'(py2_q) <<< Q2) + SUM_W'(rty_q) + SUM_W'(ktx_q) - SUM_W'(itz_q) + RND;
  assign sumz = (SUM_W'(pz2_q) <<< Q2) + SUM_W'(rtz_q) + SUM_W'(ity_q) - SUM_W'(jtx_q) + RND;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox_q <= sumx[SUM_W-1:Q2];
      oy_q <= sumy[SUM_W-1:Q2];
      oz_q <= sumz[SUM_W-1:Q2];
    end
  end

  // Stage 4: denominator, scaled coordinates, saturated depth.
  logic signed [DEN_W-1:0] den_d, den4_q, den5_q, den6_q;
  logic signed [NX_W-1:0]  nx4_q, ny4_q;
  logic signed [15:0]      depth_d, depth4_q, depth5_q, depth6_q;
  logic                    behind4_q, behind5_q, behind6_q;
  logic v4_q;

  assign den_d = (DEN_W'(dist_s) <<< PT_FRAC) + DEN_W'(oz_q) * DEN_W'(size_s);

  always_comb begin
    if (oz_q > ROT_W'(32767)) begin
      depth_d = 16'sh7fff;
    end else if (oz_q < -ROT_W'(32768)) begin
      depth_d = -16'sh8000;
    end else begin
      depth_d = oz_q[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      den4_q    <= den_d;
      nx4_q     <= NX_W'(ox_q) * NX_W'(size_s);
      ny4_q     <= NX_W'(oy_q) * NX_W'(size_s);
      depth4_q  <= depth_d;
      behind4_q <= den_d[DEN_W-1] || (den_d == '0);
    end
  end

  // Stage 5: numerators.
  logic signed [NUM_W-1:0] numx5_q, numy5_q;
  logic v5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      numx5_q   <= NUM_W'(nx4_q) * NUM_W'(dist_s);
      numy5_q   <= NUM_W'(ny4_q) * NUM_W'(dist_s);
      den5_q    <= den4_q;
      depth5_q  <= depth4_q;
      behind5_q <= behind4_q;
    end
  end

  // Stage 6: magnitudes and quotient signs; y is negated, so its sign flips.
  logic [MAG_W-1:0] magx6_q, magy6_q;
  logic negx6_q, negy6_q;
  logic v6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      magx6_q   <= numx5_q[NUM_W-1] ? MAG_W'(-numx5_q) : MAG_W'(numx5_q);
      magy6_q   <= numy5_q[NUM_W-1] ? MAG_W'(-numy5_q) : MAG_W'(numy5_q);
      negx6_q   <= numx5_q[NUM_W-1];
      negy6_q   <= !numy5_q[NUM_W-1];
      den6_q    <= den5_q;
      depth6_q  <= depth5_q;
      behind6_q <= behind5_q;
    end
  end

  // Stage 7: divider setup; quotients that cannot land on screen saturate.
  div_word_t div_d;
  div_word_t div0_q;
  div_word_t div_w [0:QUO_W];
  logic [CMP_W-1:0] den_top;

  assign den_top = CMP_W'(den6_q[DEN_W-2:0]) << QUO_W;

  always_comb begin
    div_d        = '0;
    div_d.valid  = v6_q;
    div_d.behind = behind6_q;
    div_d.depth  = depth6_q;
    div_d.den    = den6_q[DEN_W-2:0];
    div_d.x.rem  = magx6_q;
    div_d.x.neg  = negx6_q;
    div_d.x.sat  = CMP_W'(magx6_q) >= den_top;
    div_d.y.rem  = magy6_q;
    div_d.y.neg  = negy6_q;
    div_d.y.sat  = CMP_W'(magy6_q) >= den_top;
  end

  // Valid bits of the arithmetic stages and the divider setup register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      v6_q      <= 1'b0;
      div0_q    <= '0;
    end else if (en) begin
      v1_q      <= in_valid_i;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      v5_q      <= v4_q;
      v6_q      <= v5_q;
      div0_q    <= div_d;
    end
  end

  assign div_w[0] = div0_q;

  // Divider steps, most significant quotient bit first.
  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    qrp_div_step u_step (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .bit_idx_i (4'(QUO_W - 1 - g)),
      .word_i    (div_w[g]),
      .word_o    (div_w[g+1])
    );
  end

  // Final: sign, centre offset and clamping.
  div_word_t            last;
  logic [QUO_W:0]       qmag_x, qmag_y;
  logic signed [SX_W-1:0] sx, sy, xhi, ylo, yhi;
  logic [10:0]          ylo_raw;
  qrp_out_t             res;

  assign last = div_w[QUO_W];

  always_comb begin
    qmag_x  = last.x.sat ? (QUO_W+1)'(1) << QUO_W : {1'b0, last.x.quo};
    qmag_y  = last.y.sat ? (QUO_W+1)'(1) << QUO_W : {1'b0, last.y.quo};
    sx      = SX_W'($signed({1'b0, center_x_q}))
            + (last.x.neg ? -SX_W'($signed({1'b0, qmag_x})) : SX_W'($signed({1'b0, qmag_x})));
    sy      = SX_W'($signed({1'b0, center_y_q}))
            + (last.y.neg ? -SX_W'($signed({1'b0, qmag_y})) : SX_W'($signed({1'b0, qmag_y})));
    xhi     = (screen_width_q >= 10'd4) ? SX_W'($signed({1'b0, screen_width_q - 10'd2}))
                                        : SX_W'(2);
    ylo_raw = {1'b0, content_top_q} + 11'd2;
    ylo     = (ylo_raw > 11'd1023) ? SX_W'(1023) : SX_W'($signed({1'b0, ylo_raw}));
    yhi     = SX_W'($signed({1'b0, y_limit_q}));
    res.rotated_depth = last.depth;
    res.behind_viewer = last.behind;
    if (last.behind) begin
      res.screen_x = xhi[9:0];
      res.screen_y = yhi[9:0];
    end else begin
      if (sx < SX_W'(2)) begin
        res.screen_x = 10'd2;
      end else if (sx > xhi) begin
        res.screen_x = xhi[9:0];
      end else begin
        res.screen_x = sx[9:0];
      end
      if (sy < ylo) begin
        res.screen_y = ylo[9:0];
      end else if (sy > yhi) begin
        res.screen_y = yhi[9:0];
      end else begin
        res.screen_y = sy[9:0];
      end
    end
  end

  // Output register and skid entry.
  logic     out_valid_q, out_take, arrive;
  qrp_out_t out_q, skid_q;

  assign out_take = out_valid_q && !out_stall_i;
  assign arrive   = en && last.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_take) begin
      out_valid_q <= arrive;
    end else if (arrive) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || out_take) begin
      out_q <= res;
    end else begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

[design/qrp_div_step.sv]
// One restoring division step that produces one quotient bit for both coordinates.
`default_nettype none
module qrp_div_step
  import qrp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic [3:0]  bit_idx_i,
  input  wire div_word_t   word_i,
  output div_word_t        word_o
);

  div_word_t        word_d, word_q;
  logic [CMP_W-1:0] cmp;

  // Shifted divisor for this bit position.
  assign cmp = CMP_W'(word_i.den) << bit_idx_i;

  // Subtract where it fits and set the quotient bit.
  always_comb begin
    word_d = word_i;
    if (!word_i.x.sat && (CMP_W'(word_i.x.rem) >= cmp)) begin
      word_d.x.rem = MAG_W'(CMP_W'(word_i.x.rem) - cmp);
      word_d.x.quo[bit_idx_i] = 1'b1;
    end
    if (!word_i.y.sat && (CMP_W'(word_i.y.rem) >= cmp)) begin
      word_d.y.rem = MAG_W'(CMP_W'(word_i.y.rem) - cmp);
      word_d.y.quo[bit_idx_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else if (en_i) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule
`default_nettype wire

[tb/qrp_checker.sv]
// Checker that watches the projection block's channels, predicts each result and compares it.
`timescale 1ns / 1ps
`default_nettype none
module qrp_checker
  import qrp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire qrp_in_t     in_data_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire qrp_out_t    out_data_i,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [11:0] cfg_data_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               results_seen_o,
  output int               behind_seen_o
);

  // Register copies used for prediction.
  longint dist_q, size_q, cx_q, cy_q, width_q, top_q, ylim_q;
  qrp_out_t projected_q[$];

  // Divides and truncates toward zero.
  function automatic longint div_trunc(longint n, longint d);
    longint q;
    q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  // Rounds a value at 2*QUAT_FRAC_BITS extra fraction bits to nearest, ties up.
  function automatic longint round_rot(longint v);
    return (v + (longint'(1) << (2 * QUAT_FRAC_BITS - 1))) >>> (2 * QUAT_FRAC_BITS);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Rotates the point by the quaternion and projects it to the screen.
  function automatic qrp_out_t project_point(qrp_in_t p);
    longint r, i, j, k, x, y, z, unit, tx, ty, tz, ox, oy, oz, den, xhi, ylo, sx, sy;
    qrp_out_t o;
    r = p.quat_r; i = p.quat_i; j = p.quat_j; k = p.quat_k;
    x = p.point_x; y = p.point_y; z = p.point_z;
    unit = longint'(1) << (2 * QUAT_FRAC_BITS);
    tx = 2 * (j * z - k * y);
    ty = 2 * (k * x - i * z);
    tz = 2 * (i * y - j * x);
    ox = round_rot(x * unit + r * tx + (j * tz - k * ty));
    oy = round_rot(y * unit + r * ty + (k * tx - i * tz));
    oz = round_rot(z * unit + r * tz + (i * ty - j * tx));
    den = dist_q * 4096 + oz * size_q;
    xhi = (width_q >= 4) ? width_q - 2 : 2;
    ylo = top_q + 2;
    if (ylo > 1023) ylo = 1023;
    if (den <= 0) begin
      sx = xhi;
      sy = ylim_q;
    end else begin
      sx = clamp(cx_q + div_trunc(ox * size_q * dist_q, den), 2, xhi);
      sy = clamp(cy_q + div_trunc(-oy * size_q * dist_q, den), ylo, ylim_q);
    end
    o.screen_x = sx[9:0];
    o.screen_y = sy[9:0];
    o.rotated_depth = 16'(clamp(oz, -32768, 32767));
    o.behind_viewer = (den <= 0);
    return o;
  endfunction

  assign pending_o = projected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    qrp_out_t want;
    if (!rst_ni) begin
      dist_q = 256; size_q = 50; cx_q = 120; cy_q = 140;
      width_q = 240; top_q = 40; ylim_q = 248;
      projected_q.delete();
      fail_count_o = 0;
      results_seen_o = 0;
      behind_seen_o = 0;
    end else begin
      // Register writes.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PROJ_DIST:    dist_q = cfg_data_i;
          CFG_CUBE_SIZE:    size_q = cfg_data_i[9:0];
          CFG_CENTER_X:     cx_q = cfg_data_i[9:0];
          CFG_CENTER_Y:     cy_q = cfg_data_i[9:0];
          CFG_SCREEN_WIDTH: width_q = cfg_data_i[9:0];
          CFG_CONTENT_TOP:  top_q = cfg_data_i[9:0];
          CFG_Y_LIMIT:      ylim_q = cfg_data_i[9:0];
          default: ;
        endcase
      end
      // Input transfers.
      if (in_valid_i && !in_stall_i) projected_q.push_back(project_point(in_data_i));
      // Output transfers.
      if (out_valid_i && !out_stall_i) begin
        results_seen_o++;
        if (projected_q.size() == 0) begin
          $error("result with no expectation waiting: %p", out_data_i);
          fail_count_o++;
        end else begin
          want = projected_q.pop_front();
          if (want.behind_viewer) behind_seen_o++;
          if (out_data_i.screen_x !== want.screen_x) begin
            $error("screen_x: expected %0d, actual %0d", want.screen_x, out_data_i.screen_x);
            fail_count_o++;
          end
          if (out_data_i.screen_y !== want.screen_y) begin
            $error("screen_y: expected %0d, actual %0d", want.screen_y, out_data_i.screen_y);
            fail_count_o++;
          end
          if (out_data_i.rotated_depth !== want.rotated_depth) begin
            $error("rotated_depth: expected %0d, actual %0d", want.rotated_depth,
                   out_data_i.rotated_depth);
            fail_count_o++;
          end
          if (out_data_i.behind_viewer !== want.behind_viewer) begin
            $error("behind_viewer: expected %0d, actual %0d", want.behind_viewer,
                   out_data_i.behind_viewer);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

[tb/tb_quaternion_rotate_and_project.sv]
// Top of the projection block testbench: stimulus, register phases and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_quaternion_rotate_and_project
  import qrp_pkg::*;
();

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  qrp_in_t in_data;
  qrp_out_t out_data;
  logic [2:0] cfg_index;
  logic [11:0] cfg_data;
  int fail_count, pending, results_seen, behind_seen;
  int idle_cycles;
  int items_sent;
  logic hold_off;
  logic holding;

  quaternion_rotate_and_project uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  qrp_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending),
    .results_seen_o(results_seen), .behind_seen_o(behind_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Gap length: mostly short, sometimes long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Receiver stall: random gaps, plus a long hold-off on request.
  initial begin
    int n;
    out_stall = 1'b0;
    holding = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        holding = 1'b1;
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
        out_stall <= 1'b0;
        holding = 1'b0;
        @(posedge clk);
      end else begin
        n = ($urandom_range(3) == 0) ? 0 : gap_len();
        out_stall <= (n != 0);
        repeat (n > 0 ? n : 1) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(6, 1)) @(posedge clk);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("quaternion_rotate_and_project test failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Sends one point; the valid stays high when the next one follows directly.
  task automatic send_point(input qrp_in_t p, input bit allow_gaps);
    int n;
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
    items_sent++;
    n = allow_gaps ? gap_len() : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic finish_burst();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_quat_part();
    int p;
    p = $urandom_range(9);
    if (p == 0) return 16'sd16384;
    if (p == 1) return -16'sd16384;
    return 16'($urandom_range(32768) - 16384);
  endfunction

  // Random point; the quaternion is nearly unit most of the time, else arbitrary.
  function automatic qrp_in_t rand_point();
    qrp_in_t p;
    real a, ux, uy, uz, nrm;
    if ($urandom_range(4) != 0) begin
      a = $urandom_range(6283) / 1000.0;
      ux = $urandom_range(2000) / 1000.0 - 1.0;
      uy = $urandom_range(2000) / 1000.0 - 1.0;
      uz = $urandom_range(2000) / 1000.0 - 1.0;
      nrm = $sqrt(ux * ux + uy * uy + uz * uz) + 1e-6;
      p.quat_r = 16'($rtoi(16384.0 * $cos(a / 2)));
      p.quat_i = 16'($rtoi(16384.0 * $sin(a / 2) * ux / nrm));
      p.quat_j = 16'($rtoi(16384.0 * $sin(a / 2) * uy / nrm));
      p.quat_k = 16'($rtoi(16384.0 * $sin(a / 2) * uz / nrm));
    end else begin
      p.quat_r = rand_quat_part();
      p.quat_i = rand_quat_part();
      p.quat_j = rand_quat_part();
      p.quat_k = rand_quat_part();
    end
    if ($urandom_range(3) == 0) begin
      p.point_x = 16'($urandom);
      p.point_y = 16'($urandom);
      p.point_z = 16'($urandom);
    end else begin
      p.point_x = 16'($urandom_range(8192) - 4096);
      p.point_y = 16'($urandom_range(8192) - 4096);
      p.point_z = 16'($urandom_range(8192) - 4096);
    end
    return p;
  endfunction

  function automatic qrp_in_t make_point(int r, int i, int j, int k, int x, int y, int z);
    qrp_in_t p;
    p.quat_r = 16'(r); p.quat_i = 16'(i); p.quat_j = 16'(j); p.quat_k = 16'(k);
    p.point_x = 16'(x); p.point_y = 16'(y); p.point_z = 16'(z);
    return p;
  endfunction

  task automatic random_burst(input int count);
    for (int n = 0; n < count; n++) send_point(rand_point(), 1'b1);
    finish_burst();
  endtask

  initial begin
    qrp_in_t dir_pts[$];
    hold_off = 1'b0;
    items_sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_PROJ_DIST;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed points under the reset registers: identity, extremes, behind viewer.
    dir_pts.push_back(make_point(16384, 0, 0, 0, 4096, 4096, 4096));
    dir_pts.push_back(make_point(16384, 0, 0, 0, 0, 0, 0));
    dir_pts.push_back(make_point(16384, 0, 0, 0, 32767, -32768, 0));
    dir_pts.push_back(make_point(16384, 0, 0, 0, -32768, 32767, -32768));
    dir_pts.push_back(make_point(16384, 0, 0, 0, 0, 0, -32768));
    dir_pts.push_back(make_point(0, 16384, 0, 0, 4096, 2048, 1024));
    dir_pts.push_back(make_point(0, 0, 16384, 0, 4096, 2048, 1024));
    dir_pts.push_back(make_point(0, 0, 0, 16384, 4096, 2048, 1024));
    dir_pts.push_back(make_point(-16384, -16384, -16384, -16384, 32767, 32767, 32767));
    dir_pts.push_back(make_point(16384, 16384, 16384, 16384, -32768, -32768, -32768));
    dir_pts.push_back(make_point(11585, 11585, 0, 0, 0, 4096, 0));
    dir_pts.push_back(make_point(16384, 0, 0, 0, 0, 0, -20972));
    dir_pts.push_back(make_point(-1, -1, -1, -1, -1, -1, -1));
    dir_pts.push_back(make_point(1, 1, 1, 1, 1, 1, 1));
    foreach (dir_pts[n]) send_point(dir_pts[n], 1'b0);
    finish_burst();

    // Extreme register settings: zero distance and size, narrow screen, inverted y bounds.
    write_reg(CFG_PROJ_DIST, 12'd0);
    write_reg(CFG_CUBE_SIZE, 12'd0);
    write_reg(CFG_SCREEN_WIDTH, 12'd3);
    write_reg(CFG_CONTENT_TOP, 12'd1022);
    write_reg(CFG_Y_LIMIT, 12'd0);
    write_reg(CFG_CENTER_X, 12'd0);
    write_reg(CFG_CENTER_Y, 12'd1023);
    foreach (dir_pts[n]) send_point(dir_pts[n], 1'b0);
    finish_burst();

    // Largest values for distance, size, screen width, y limit and centre x.
    write_reg(CFG_PROJ_DIST, 12'd4095);
    write_reg(CFG_CUBE_SIZE, 12'd1023);
    write_reg(CFG_SCREEN_WIDTH, 12'd1023);
    write_reg(CFG_CONTENT_TOP, 12'd500);
    write_reg(CFG_Y_LIMIT, 12'd1023);
    write_reg(CFG_CENTER_X, 12'd1023);
    write_reg(CFG_CENTER_Y, 12'd0);
    random_burst(150);

    // Smallest nonzero distance and size, so that points far enough back fall behind the viewer.
    write_reg(CFG_PROJ_DIST, 12'd1);
    write_reg(CFG_CUBE_SIZE, 12'd1);
    write_reg(CFG_CONTENT_TOP, 12'd0);
    write_reg(CFG_Y_LIMIT, 12'd100);
    write_reg(CFG_SCREEN_WIDTH, 12'd4);
    random_burst(120);

    write_reg(CFG_PROJ_DIST, 12'd300);
    write_reg(CFG_CUBE_SIZE, 12'd400);
    write_reg(CFG_CENTER_X, 12'd512);
    write_reg(CFG_CENTER_Y, 12'd384);
    write_reg(CFG_SCREEN_WIDTH, 12'd800);
    write_reg(CFG_CONTENT_TOP, 12'd20);
    write_reg(CFG_Y_LIMIT, 12'd700);
    random_burst(130);

    // Long receiver hold-off while points keep coming, so the input stalls.
    hold_off = 1'b1;
    wait (holding);
    hold_off = 1'b0;
    for (int n = 0; n < 40; n++) send_point(rand_point(), 1'b0);
    finish_burst();

    // Back to the default settings.
    write_reg(CFG_PROJ_DIST, 12'd256);
    write_reg(CFG_CUBE_SIZE, 12'd50);
    write_reg(CFG_CENTER_X, 12'd120);
    write_reg(CFG_CENTER_Y, 12'd140);
    write_reg(CFG_SCREEN_WIDTH, 12'd240);
    write_reg(CFG_CONTENT_TOP, 12'd40);
    write_reg(CFG_Y_LIMIT, 12'd248);
    random_burst(230);

    $display("Sent %0d points, checked %0d results, %0d of them behind the viewer.",
             items_sent, results_seen, behind_seen);
    $display("Covered five register settings including zero, narrow and largest values.");
    if (fail_count == 0 && pending == 0)
      $display("quaternion_rotate_and_project test passed");
    else
      $display("quaternion_rotate_and_project test failed");
    $finish;
  end

endmodule
`default_nettype wire
